>>> rtl/lcdnw_pkg.sv
// Shared types and constants for the character LCD nibble writer.
`timescale 1ns / 1ps
`default_nettype none

package lcdnw_pkg;

    // APB register map
    localparam int unsigned ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_TICKS_PER_US = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_SETTLE       = 3'd4;

    localparam int unsigned TPM_W    = 10;
    localparam int unsigned SETTLE_W = 24;

    localparam logic [TPM_W-1:0]    TPM_RESET    = 10'd1;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 24'd10000;

    // Request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Sequencer phases
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_SETTLE   = 4'd1;
    localparam logic [3:0] PH_POLL_HI  = 4'd2;
    localparam logic [3:0] PH_POLL_LO  = 4'd3;
    localparam logic [3:0] PH_POLL_P1  = 4'd4;
    localparam logic [3:0] PH_POLL_P2  = 4'd5;
    localparam logic [3:0] PH_POLL_P3  = 4'd6;
    localparam logic [3:0] PH_UP_SETUP = 4'd7;
    localparam logic [3:0] PH_UP_HIGH  = 4'd8;
    localparam logic [3:0] PH_UP_HOLD  = 4'd9;
    localparam logic [3:0] PH_LO_SETUP = 4'd10;
    localparam logic [3:0] PH_LO_HIGH  = 4'd11;
    localparam logic [3:0] PH_LO_HOLD  = 4'd12;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
        logic       is_data;
        logic       check_busy;
        logic       send_low_nibble;
        logic       busy_in;
    } in_t;

    typedef struct packed {
        logic       rs_pin;
        logic       rw_pin;
        logic       enable_pin;
        logic [3:0] nibble_out;
        logic       bus_drive;
        logic       in_progress;
        logic       request_taken;
        logic       write_done;
    } out_t;

    typedef struct packed {
        logic       rs;
        logic       rw;
        logic       e;
        logic       drive;
        logic [3:0] nibble;
    } pins_t;

    typedef struct packed {
        logic is_data;
        logic check_busy;
        logic send_low;
    } flags_t;

    typedef struct packed {
        logic [TPM_W-1:0]    ticks_per_us;
        logic [SETTLE_W-1:0] settle_ticks;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/lcdnw_regs.sv
// APB configuration registers for the nibble writer.
`timescale 1ns / 1ps
`default_nettype none

module lcdnw_regs
    import lcdnw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [TPM_W-1:0]    tpm_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpm_reg    <= TPM_RESET;
            settle_reg <= SETTLE_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr)
                ADDR_TICKS_PER_US: tpm_reg    <= pwdata[TPM_W-1:0];
                ADDR_SETTLE:       settle_reg <= pwdata[SETTLE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_TICKS_PER_US: prdata = {{(32-TPM_W){1'b0}}, tpm_reg};
            ADDR_SETTLE:       prdata = {{(32-SETTLE_W){1'b0}}, settle_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.ticks_per_us = tpm_reg;
    assign cfg.settle_ticks = settle_reg;

endmodule

`default_nettype wire

>>> rtl/lcdnw_seq.sv
// Write sequencer: phase machine, interval counter and pin levels.
`timescale 1ns / 1ps
`default_nettype none

module lcdnw_seq
    import lcdnw_pkg::*;
#(
    parameter int unsigned CNT_W = 24
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire in_t  item,
    input  wire cfg_t cfg,
    output out_t      result
);

    localparam logic [31:0] CNT_MAX32 =
        (CNT_W >= 32) ? 32'hFFFF_FFFF : ((32'd1 << CNT_W) - 32'd1);
    localparam logic [CNT_W-1:0] CNT_ZERO = '0;
    localparam logic [CNT_W-1:0] CNT_ONE  = {{(CNT_W-1){1'b0}}, 1'b1};

    logic [3:0]       phase_reg,     phase_next;
    logic [CNT_W-1:0] cnt_reg,       cnt_next;
    logic [7:0]       byte_reg,      byte_next;
    flags_t           flags_reg,     flags_next;
    logic             busy_seen_reg, busy_seen_next;
    pins_t            pins_reg,      pins_next;

    logic [31:0]      tpm32;
    logic [31:0]      settle32;
    logic [CNT_W-1:0] interval;
    logic [CNT_W-1:0] settle_sat;
    logic [CNT_W-1:0] cnt_dec;
    logic             go;
    logic [3:0]       target;
    logic             taken;
    logic             done;

    // zero microsecond setting counts as one tick; both saturate to the counter
    always_comb
    begin
        tpm32    = {{(32-TPM_W){1'b0}}, cfg.ticks_per_us};
        settle32 = {{(32-SETTLE_W){1'b0}}, cfg.settle_ticks};
        if (tpm32 == 32'd0)
            interval = CNT_ONE;
        else if (tpm32 > CNT_MAX32)
            interval = CNT_MAX32[CNT_W-1:0];
        else
            interval = tpm32[CNT_W-1:0];
        if (settle32 > CNT_MAX32)
            settle_sat = CNT_MAX32[CNT_W-1:0];
        else
            settle_sat = settle32[CNT_W-1:0];
    end

    assign cnt_dec = (cnt_reg == CNT_ZERO) ? CNT_ZERO : cnt_reg - CNT_ONE;

    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        byte_next      = byte_reg;
        flags_next     = flags_reg;
        busy_seen_next = busy_seen_reg;
        pins_next      = pins_reg;
        go             = 1'b0;
        target         = PH_IDLE;
        taken          = 1'b0;
        done           = 1'b0;

        if (item.kind == KIND_WRITE)
        begin
            if (phase_reg == PH_IDLE)
            begin
                taken               = 1'b1;
                byte_next           = item.byte_value;
                flags_next.is_data    = item.is_data;
                flags_next.check_busy = item.check_busy;
                flags_next.send_low   = item.send_low_nibble;
                busy_seen_next      = 1'b0;
                go                  = 1'b1;
                if (item.check_busy)
                    target = PH_POLL_HI;
                else if (cfg.settle_ticks == '0)
                    target = PH_UP_SETUP;
                else
                    target = PH_SETTLE;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            cnt_next = cnt_dec;
            if (cnt_dec == CNT_ZERO)
            begin
                unique case (phase_reg)
                    PH_SETTLE:
                    begin
                        go = 1'b1; target = PH_UP_SETUP;
                    end
                    PH_POLL_HI:
                    begin
                        busy_seen_next = item.busy_in;
                        go = 1'b1; target = PH_POLL_LO;
                    end
                    PH_POLL_LO:
                    begin
                        go = 1'b1; target = PH_POLL_P1;
                    end
                    PH_POLL_P1:
                    begin
                        go = 1'b1; target = PH_POLL_P2;
                    end
                    PH_POLL_P2:
                    begin
                        go = 1'b1; target = PH_POLL_P3;
                    end
                    PH_POLL_P3:
                    begin
                        go = 1'b1;
                        target = busy_seen_reg ? PH_POLL_HI : PH_UP_SETUP;
                    end
                    PH_UP_SETUP:
                    begin
                        go = 1'b1; target = PH_UP_HIGH;
                    end
                    PH_UP_HIGH:
                    begin
                        go = 1'b1; target = PH_UP_HOLD;
                    end
                    PH_UP_HOLD:
                    begin
                        if (flags_reg.send_low)
                        begin
                            go = 1'b1; target = PH_LO_SETUP;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            cnt_next   = CNT_ZERO;
                            done       = 1'b1;
                        end
                    end
                    PH_LO_SETUP:
                    begin
                        go = 1'b1; target = PH_LO_HIGH;
                    end
                    PH_LO_HIGH:
                    begin
                        go = 1'b1; target = PH_LO_HOLD;
                    end
                    default:
                    begin
                        pins_next.e = 1'b0;
                        phase_next  = PH_IDLE;
                        cnt_next    = CNT_ZERO;
                        done        = 1'b1;
                    end
                endcase
            end
        end

        // entry actions of the new phase
        if (go)
        begin
            phase_next = target;
            cnt_next   = interval;
            unique case (target)
                PH_SETTLE:
                    cnt_next = settle_sat;
                PH_POLL_HI:
                begin
                    pins_next.rs    = 1'b0;
                    pins_next.drive = 1'b0;
                    pins_next.rw    = 1'b1;
                    pins_next.e     = 1'b1;
                end
                PH_POLL_P2, PH_UP_HIGH, PH_LO_HIGH:
                    pins_next.e = 1'b1;
                PH_UP_SETUP:
                begin
                    pins_next.rw     = 1'b0;
                    pins_next.drive  = 1'b1;
                    pins_next.rs     = flags_next.is_data;
                    pins_next.nibble = byte_next[7:4];
                    pins_next.e      = 1'b0;
                end
                PH_LO_SETUP:
                begin
                    pins_next.nibble = byte_next[3:0];
                    pins_next.e      = 1'b0;
                end
                default:
                    pins_next.e = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cnt_reg       <= CNT_ZERO;
            byte_reg      <= 8'd0;
            flags_reg     <= '0;
            busy_seen_reg <= 1'b0;
            pins_reg      <= '{rs: 1'b0, rw: 1'b0, e: 1'b0, drive: 1'b1, nibble: 4'd0};
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            byte_reg      <= byte_next;
            flags_reg     <= flags_next;
            busy_seen_reg <= busy_seen_next;
            pins_reg      <= pins_next;
        end
    end

    always_comb
    begin
        result.rs_pin        = pins_next.rs;
        result.rw_pin        = pins_next.rw;
        result.enable_pin    = pins_next.e;
        result.nibble_out    = pins_next.drive ? pins_next.nibble : 4'd0;
        result.bus_drive     = pins_next.drive;
        result.in_progress   = (phase_next != PH_IDLE);
        result.request_taken = taken;
        result.write_done    = done;
    end

endmodule

`default_nettype wire

>>> rtl/char_lcd_nibble_writer.sv
// Top level of the character LCD 4-bit nibble writer.
//
// Input channel (in_valid/in_ready/in_data): each request is either a write
// request (byte plus data/busy-poll/low-nibble flags) or one clock tick that
// carries the D7 level read back from the display. Every request yields
// exactly one result on the output channel (out_valid/out_ready/out_data):
// pin levels RS, RW, E, D7..D4, bus drive, plus in-progress, request-taken
// and write-done flags.
// The result shows in the cycle after acceptance. Throughput: one request per
// cycle; the sequencer state and the result register both update at the
// accepting edge, so the phase machine never stalls the input on its own.
// The result register acts as the output stage: a new request is taken
// whenever it is empty or being drained in the same cycle. If the receiver
// holds out_ready low, in_ready drops and the sequencer freezes.
// Timing on the display side is counted in tick requests: each setup, strobe
// and hold interval lasts ticks_per_microsecond ticks (register 0, byte
// address 0), the settle delay is settle_delay_ticks (register 1, address 4).
// Reset: phase idle, all pins low with the bus driven, registers at defaults.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_writer
    import lcdnw_pkg::*;
#(
    parameter int unsigned DELAY_COUNT_BITS = 24
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_t               in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_t                   out_data
);

    cfg_t cfg;
    out_t result;
    logic step;
    logic out_valid_reg;
    out_t out_data_reg;

    lcdnw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // take a request when the result slot is free or emptying this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    lcdnw_seq #(
        .CNT_W (DELAY_COUNT_BITS)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_data),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("request accepted while result stalled");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted request produced no result");

    a_done_ends_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.write_done) |-> !out_data.in_progress)
        else $error("write done while sequence still running");

    a_taken_starts_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.request_taken) |-> out_data.in_progress)
        else $error("request taken without starting a sequence");
`endif

endmodule

`default_nettype wire

>>> verif/char_lcd_nibble_writer_test.sv
// Self-checking testbench for the character LCD nibble writer.
`timescale 1ns / 1ps

module char_lcd_nibble_writer_test;
    import lcdnw_pkg::*;

    // Rows of the directed table: a request (repeated n times) or a register write
    typedef enum logic {ROW_ITEM, ROW_CONFIG} row_op_e;

    typedef struct packed {
        row_op_e           op;
        logic              kind;
        logic [7:0]        byte_value;
        logic              is_data;
        logic              check_busy;
        logic              send_low;
        logic              busy_in;
        logic [15:0]       repeats;
        logic              typed;      // result below is checked on the last repeat
        out_t              result;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       value;
    } stim_row_t;

    localparam int unsigned DIRECTED_ROWS   = 24;
    localparam int unsigned RANDOM_ROUNDS   = 6;
    localparam int unsigned ITEMS_PER_ROUND = 80;
    localparam int unsigned COUNT_W         = 24;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    in_t               in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_t              out_data;

    always #1 clk = ~clk;

    char_lcd_nibble_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the sequencer and its registers
    // ------------------------------------------------------------------
    logic [TPM_W-1:0]    cfg_ticks_per_us = TPM_RESET;
    logic [SETTLE_W-1:0] cfg_settle       = SETTLE_RESET;
    logic [3:0]          lcd_phase        = PH_IDLE;
    logic [COUNT_W-1:0]  lcd_count        = '0;
    logic [7:0]          lcd_byte         = '0;
    flags_t              lcd_flags        = '0;
    logic                lcd_busy_seen    = 1'b0;
    pins_t               lcd_pins         = '{rs: 1'b0, rw: 1'b0, e: 1'b0, drive: 1'b1,
                                              nibble: 4'h0};

    out_t        pending_pins [$];   // expected results, oldest first
    out_t        oldest_pins;
    int unsigned mismatch_count  = 0;
    int unsigned results_checked = 0;
    int unsigned requests_sent   = 0;
    int unsigned writes_started  = 0;
    int unsigned writes_done     = 0;
    int unsigned register_writes = 0;

    // Idle-gap windows: each side alternates between gappy and gap-free stretches
    int unsigned send_window = 0;
    bit          send_quiet  = 1'b0;
    int unsigned recv_window = 0;
    bit          recv_quiet  = 1'b0;

    // Enter a phase and load the interval counter; pins change only on entry or when a write ends
    function automatic void start_interval(logic [3:0] next);
        lcd_phase = next;
        lcd_count = (cfg_ticks_per_us == 0) ? COUNT_W'(1) : COUNT_W'(cfg_ticks_per_us);
        case (next)
            PH_SETTLE:
                lcd_count = cfg_settle;
            PH_POLL_HI:
            begin
                // status read: RS low, RW high, bus released, strobe up
                lcd_pins.rs    = 1'b0;
                lcd_pins.drive = 1'b0;
                lcd_pins.rw    = 1'b1;
                lcd_pins.e     = 1'b1;
            end
            PH_POLL_P2, PH_UP_HIGH, PH_LO_HIGH:
                lcd_pins.e = 1'b1;
            PH_UP_SETUP:
            begin
                lcd_pins.rw     = 1'b0;
                lcd_pins.drive  = 1'b1;
                lcd_pins.rs     = lcd_flags.is_data;
                lcd_pins.nibble = lcd_byte[7:4];
                lcd_pins.e      = 1'b0;
            end
            PH_LO_SETUP:
            begin
                lcd_pins.nibble = lcd_byte[3:0];
                lcd_pins.e      = 1'b0;
            end
            default:
                lcd_pins.e = 1'b0;
        endcase
    endfunction

    // Apply one accepted request to the predictor; returns the pin levels it yields
    function automatic out_t advance_display_bus(in_t req);
        out_t res;
        logic taken;
        logic done;
        taken = 1'b0;
        done  = 1'b0;
        if (req.kind == KIND_WRITE) begin
            // requests are dropped while a sequence runs
            if (lcd_phase == PH_IDLE) begin
                taken         = 1'b1;
                lcd_byte      = req.byte_value;
                lcd_flags     = {req.is_data, req.check_busy, req.send_low_nibble};
                lcd_busy_seen = 1'b0;
                if (lcd_flags.check_busy)
                    start_interval(PH_POLL_HI);
                else if (cfg_settle == 0)
                    start_interval(PH_UP_SETUP);
                else
                    start_interval(PH_SETTLE);
            end
        end
        else if (lcd_phase != PH_IDLE) begin
            if (lcd_count != 0)
                lcd_count--;
            if (lcd_count == 0) begin
                case (lcd_phase)
                    PH_SETTLE:   start_interval(PH_UP_SETUP);
                    PH_POLL_HI:
                    begin
                        lcd_busy_seen = req.busy_in;   // D7 sampled as strobe ends
                        start_interval(PH_POLL_LO);
                    end
                    PH_POLL_LO:  start_interval(PH_POLL_P1);
                    PH_POLL_P1:  start_interval(PH_POLL_P2);
                    PH_POLL_P2:  start_interval(PH_POLL_P3);
                    PH_POLL_P3:  start_interval(lcd_busy_seen ? PH_POLL_HI : PH_UP_SETUP);
                    PH_UP_SETUP: start_interval(PH_UP_HIGH);
                    PH_UP_HIGH:  start_interval(PH_UP_HOLD);
                    PH_LO_SETUP: start_interval(PH_LO_HIGH);
                    PH_LO_HIGH:  start_interval(PH_LO_HOLD);
                    default:
                    begin
                        if (lcd_phase == PH_UP_HOLD && lcd_flags.send_low)
                            start_interval(PH_LO_SETUP);
                        else begin
                            lcd_pins.e = 1'b0;
                            lcd_phase  = PH_IDLE;
                            lcd_count  = '0;
                            done       = 1'b1;
                        end
                    end
                endcase
            end
        end
        res.rs_pin        = lcd_pins.rs;
        res.rw_pin        = lcd_pins.rw;
        res.enable_pin    = lcd_pins.e;
        res.nibble_out    = lcd_pins.drive ? lcd_pins.nibble : 4'h0;
        res.bus_drive     = lcd_pins.drive;
        res.in_progress   = (lcd_phase != PH_IDLE);
        res.request_taken = taken;
        res.write_done    = done;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Results typed in only where obvious; the rest predicted.
    // ------------------------------------------------------------------
    function automatic stim_row_t directed_row(int unsigned n);
        case (n)
            //          op        kind       byte  d b l bsy reps  typ rs rw e nib drv ip tk dn
            // tick while idle, then a busy-polled data write of 0xFF with both nibbles
            0:  return '{ROW_ITEM, KIND_TICK,  8'h00, 0,0,0,1, 16'd1,  1,
                         '{0,0,0,4'h0,1,0,0,0}, '0, '0};
            1:  return '{ROW_ITEM, KIND_WRITE, 8'hFF, 1,1,1,0, 16'd1,  1,
                         '{0,1,1,4'h0,0,1,1,0}, '0, '0};
            // request while busy is dropped
            2:  return '{ROW_ITEM, KIND_WRITE, 8'h00, 0,1,0,0, 16'd1,  1,
                         '{0,1,1,4'h0,0,1,0,0}, '0, '0};
            // one poll with the display ready, then upper nibble set up
            3:  return '{ROW_ITEM, KIND_TICK,  8'h00, 0,0,0,0, 16'd5,  1,
                         '{1,0,0,4'hF,1,1,0,0}, '0, '0};
            4:  return '{ROW_ITEM, KIND_TICK,  8'h00, 0,0,0,0, 16'd5,  0, '0, '0, '0};
            5:  return '{ROW_ITEM, KIND_TICK,  8'h00, 0,0,0,0, 16'd1,  1,
                         '{1,0,0,4'hF,1,0,0,1}, '0, '0};
            // busy-polled command, upper nibble only; display busy for one poll
            6:  return '{ROW_ITEM, KIND_WRITE, 8'h00, 0,1,0,0, 16'd1,  1,
                         '{0,1,1,4'h0,0,1,1,0}, '0, '0};
            7:  return '{ROW_ITEM, KIND_TICK,  8'h00, 0,0,0,1, 16'd1,  0, '0, '0, '0};
            8:  return '{ROW_ITEM, KIND_TICK,  8'h00, 0,0,0,1, 16'd3,  0, '0, '0, '0};
            9:  return '{ROW_ITEM, KIND_TICK,  8'h00, 0,0,0,0, 16'd1,  0, '0, '0, '0};
            10: return '{ROW_ITEM, KIND_TICK,  8'h00, 0,0,0,0, 16'd5,  0, '0, '0, '0};
            11: return '{ROW_ITEM, KIND_TICK,  8'h00, 0,0,0,0, 16'd3,  1,
                         '{0,0,0,4'h0,1,0,0,1}, '0, '0};
            // zero microsecond setting and zero settle: write starts on the request
            12: return '{ROW_CONFIG, KIND_TICK, 8'h00, 0,0,0,0, 16'd0, 0, '0,
                         ADDR_TICKS_PER_US, 32'd0};
            13: return '{ROW_CONFIG, KIND_TICK, 8'h00, 0,0,0,0, 16'd0, 0, '0,
                         ADDR_SETTLE, 32'd0};
            14: return '{ROW_ITEM, KIND_WRITE, 8'h5A, 0,0,1,0, 16'd1,  1,
                         '{0,0,0,4'h5,1,1,1,0}, '0, '0};
            15: return '{ROW_ITEM, KIND_TICK,  8'h00, 0,0,0,0, 16'd5,  0, '0, '0, '0};
            16: return '{ROW_ITEM, KIND_TICK,  8'h00, 0,0,0,0, 16'd1,  1,
                         '{0,0,0,4'hA,1,0,0,1}, '0, '0};
            17: return '{ROW_ITEM, KIND_WRITE, 8'h80, 1,0,0,1, 16'd1,  0, '0, '0, '0};
            18: return '{ROW_ITEM, KIND_TICK,  8'h00, 0,0,0,0, 16'd3,  0, '0, '0, '0};
            // two-tick intervals, settle maximum, polled data write of 0x3C
            19: return '{ROW_CONFIG, KIND_TICK, 8'h00, 0,0,0,0, 16'd0, 0, '0,
                         ADDR_TICKS_PER_US, 32'd2};
            20: return '{ROW_CONFIG, KIND_TICK, 8'h00, 0,0,0,0, 16'd0, 0, '0,
                         ADDR_SETTLE, 32'h00FF_FFFF};
            21: return '{ROW_ITEM, KIND_WRITE, 8'h3C, 1,1,1,0, 16'd1,  1,
                         '{0,1,1,4'h0,0,1,1,0}, '0, '0};
            22: return '{ROW_ITEM, KIND_TICK,  8'h00, 0,0,0,0, 16'd21, 0, '0, '0, '0};
            23: return '{ROW_ITEM, KIND_TICK,  8'h00, 0,0,0,0, 16'd1,  1,
                         '{1,0,0,4'hC,1,0,0,1}, '0, '0};
            default: return '0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      results_checked, name, got, want));
    endtask

    // Results are compared in order against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            results_checked++;
            if (pending_pins.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          results_checked));
            else begin
                oldest_pins = pending_pins.pop_front();
                check_field("rs_pin",        out_data.rs_pin,        oldest_pins.rs_pin);
                check_field("rw_pin",        out_data.rw_pin,        oldest_pins.rw_pin);
                check_field("enable_pin",    out_data.enable_pin,    oldest_pins.enable_pin);
                check_field("nibble_out",    out_data.nibble_out,    oldest_pins.nibble_out);
                check_field("bus_drive",     out_data.bus_drive,     oldest_pins.bus_drive);
                check_field("in_progress",   out_data.in_progress,   oldest_pins.in_progress);
                check_field("request_taken", out_data.request_taken,
                            oldest_pins.request_taken);
                check_field("write_done",    out_data.write_done,    oldest_pins.write_done);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mostly no gap, some short, a few long; gap-free stretches come and go
    function automatic int unsigned next_gap(inout int unsigned window, inout bit quiet);
        int unsigned r;
        if (window == 0) begin
            window = $urandom_range(30, 120);
            quiet  = ($urandom_range(0, 3) == 0);
        end
        window--;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Present one request, hold it until taken, then record what it should yield
    task automatic send_request(in_t req, bit use_typed, out_t typed_result);
        int unsigned gap;
        out_t        predicted;
        gap = next_gap(send_window, send_quiet);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = advance_display_bus(req);
        pending_pins.push_back(use_typed ? typed_result : predicted);
        requests_sent++;
        writes_started += predicted.request_taken;
        writes_done    += predicted.write_done;
    endtask

    // Tick the sequencer to idle (display reports ready), then wait for all results
    task automatic bring_bus_idle();
        in_t req;
        while (lcd_phase != PH_IDLE) begin
            req         = in_t'($urandom);
            req.kind    = KIND_TICK;
            req.busy_in = 1'b0;
            send_request(req, 1'b0, '0);
        end
        in_valid <= 1'b0;
        while (pending_pins.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Setup and access phase write, then read back the same register
    task automatic write_register(logic [ADDR_W-1:0] addr, logic [31:0] value);
        logic [31:0] readback;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // write lands at this edge; go straight into the read setup phase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_TICKS_PER_US)
            cfg_ticks_per_us = value[TPM_W-1:0];
        else
            cfg_settle = value[SETTLE_W-1:0];
        register_writes++;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_TICKS_PER_US && readback[TPM_W-1:0] !== value[TPM_W-1:0])
            report_mismatch($sformatf("ticks_per_microsecond read %0d, wrote %0d",
                                      readback[TPM_W-1:0], value[TPM_W-1:0]));
        if (addr == ADDR_SETTLE && readback[SETTLE_W-1:0] !== value[SETTLE_W-1:0])
            report_mismatch($sformatf("settle_delay_ticks read %0d, wrote %0d",
                                      readback[SETTLE_W-1:0], value[SETTLE_W-1:0]));
    endtask

    // ------------------------------------------------------------------
    // Receiver: random back-pressure on the result channel
    // ------------------------------------------------------------------
    initial begin
        int unsigned stall;
        forever begin
            stall = next_gap(recv_window, recv_quiet);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        stim_row_t   row;
        in_t         req;
        int unsigned n;
        int unsigned k;
        int unsigned counted;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, first with the reset register values
        for (n = 0; n < DIRECTED_ROWS; n++) begin
            row = directed_row(n);
            if (row.op == ROW_CONFIG) begin
                bring_bus_idle();
                write_register(row.addr, row.value);
            end
            else begin
                req = {row.kind, row.byte_value, row.is_data, row.check_busy,
                       row.send_low, row.busy_in};
                for (k = 1; k <= row.repeats; k++)
                    send_request(req, row.typed && k == row.repeats, row.result);
            end
        end

        // random part: short intervals and settle delays so sequences complete often
        for (n = 0; n < RANDOM_ROUNDS; n++) begin
            bring_bus_idle();
            write_register(ADDR_TICKS_PER_US,
                           (n == 0) ? 32'd1 : (n == 1) ? 32'd0 : $urandom_range(1, 4));
            write_register(ADDR_SETTLE,
                           (n == 0) ? 32'd0 : (n == 1) ? 32'd1 : $urandom_range(0, 40));
            counted = 0;
            while (counted < ITEMS_PER_ROUND) begin
                req = in_t'($urandom);
                // mostly ticks while a write runs, mostly requests while idle
                if (lcd_phase == PH_IDLE)
                    req.kind = ($urandom_range(0, 9) < 7) ? KIND_WRITE : KIND_TICK;
                else
                    req.kind = ($urandom_range(0, 9) < 1) ? KIND_WRITE : KIND_TICK;
                // display reports busy often enough to repeat polls now and then
                req.busy_in = ($urandom_range(0, 9) < 4);
                // dropped requests and idle ticks do nothing, so they are not counted
                if ((req.kind == KIND_WRITE) == (lcd_phase == PH_IDLE))
                    counted++;
                send_request(req, 1'b0, '0);
            end
        end

        bring_bus_idle();
        repeat (4) @(posedge clk);

        $display("Run covered %0d requests: %0d writes started, %0d completed, %0d results",
                 requests_sent, writes_started, writes_done, results_checked);
        $display("over %0d register writes, including zero and maximum settings",
                 register_writes);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial begin
        #20_000_000;
        $display("Timeout: requests or results stalled");
        $display("DONE: errors detected");
        $finish;
    end

endmodule
